// ===== design/sbw_pkg.sv =====
package sbw_pkg;

    // Frame geometry and field widths.
    localparam int MAX_DIM  = 512;
    localparam int DIM_W    = $clog2(MAX_DIM);   // row and column index
    localparam int SIZE_W   = 10;                // frame height and width registers
    localparam int SPREAD_W = 32;                // inv_spread, unsigned Q8.24
    localparam int SAMP_W   = 16;                // spectrum samples
    localparam int OUT_W    = 48;                // weighted output parts

    // Wrapped frequency and radius.
    localparam int DIFF_W = SIZE_W + 1;          // signed wrapped index
    localparam int SQ_W   = 2 * SIZE_W;          // one squared index
    localparam int R2_W   = SQ_W + 1;            // di^2 + dj^2

    // Exponent path.
    localparam int FRAC_W   = 24;                // Q.24 exponent fraction
    localparam int XLIM_W   = 30;                // x below 64.0 in Q.24
    localparam int X_W      = R2_W + SPREAD_W;   // r2 * inv_spread
    localparam int LOG2E_W  = 31;
    localparam int LOG2E_SH = 30;
    localparam logic [LOG2E_W-1:0] LOG2E_Q30 = 31'd1549082005;
    localparam int YP_W     = XLIM_W + LOG2E_W;  // full product before the shift
    localparam int Y_W      = YP_W - LOG2E_SH;
    localparam int EXPN_W   = Y_W - FRAC_W;      // integer part of the exponent
    localparam logic [EXPN_W-1:0] EXPN_LIMIT = EXPN_W'(62);
    localparam int WGT_PRE_SH = 2;               // Q0.16 times r2 down to Q18.14

    // Exponent fraction table.
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int EXP_IDX_W = $clog2(EXP_TABLE_ENTRIES);
    localparam int EXP_VAL_W = 16;
    localparam logic [63:0] LN2_Q32 = 64'd2977044472;
    localparam int SERIES_TERMS = 20;

    // Weight and scaling.
    localparam int WPROD_W = R2_W + EXP_VAL_W;
    localparam int WGT_W   = 32;
    localparam int CORR_W  = 2 * SAMP_W + 1;
    localparam int PROD_W  = CORR_W + WGT_W + 1;
    localparam int SCALE_SH = 14;
    localparam int SH_W    = PROD_W - SCALE_SH;
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Pipeline layout: three front stages, the weight unit, two back stages.
    localparam int NSTG      = 10;
    localparam int WGT_FIRST = 3;
    localparam int WGT_STG   = 5;
    localparam int MUL_STG   = WGT_FIRST + WGT_STG;

    // Configuration registers.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_HEIGHT = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_INV_SPREAD   = 2'd2,
        CFG_CORR_MODE    = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic        [DIM_W-1:0]  row;
        logic        [DIM_W-1:0]  col;
        logic signed [SAMP_W-1:0] target_re;
        logic signed [SAMP_W-1:0] target_im;
        logic signed [SAMP_W-1:0] pattern_re;
        logic signed [SAMP_W-1:0] pattern_im;
    } t_in_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_re;
        logic signed [OUT_W-1:0] out_im;
        logic                    saturated;
    } t_out_rsp;

    typedef logic [EXP_TABLE_ENTRIES-1:0][EXP_VAL_W-1:0] t_exp_tab;

    // Integer division by the small series index, each arm by a constant.
    function automatic logic [63:0] div_small(input logic [63:0] v, input int unsigned n);
        logic [63:0] q;
        case (n)
            1:       q = v;
            2:       q = v / 64'd2;
            3:       q = v / 64'd3;
            4:       q = v / 64'd4;
            5:       q = v / 64'd5;
            6:       q = v / 64'd6;
            7:       q = v / 64'd7;
            8:       q = v / 64'd8;
            9:       q = v / 64'd9;
            10:      q = v / 64'd10;
            11:      q = v / 64'd11;
            12:      q = v / 64'd12;
            13:      q = v / 64'd13;
            14:      q = v / 64'd14;
            15:      q = v / 64'd15;
            16:      q = v / 64'd16;
            17:      q = v / 64'd17;
            18:      q = v / 64'd18;
            19:      q = v / 64'd19;
            20:      q = v / 64'd20;
            default: q = v;
        endcase
        return q;
    endfunction

    // One table entry: 2^-(k/ENTRIES) in Q0.16 from a Taylor series of exp(-a).
    function automatic logic [EXP_VAL_W-1:0] exp_entry(input int unsigned k);
        logic [63:0] a;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] e;
        a    = (64'(k) * LN2_Q32) >> EXP_IDX_W;
        sum  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int unsigned n = 1; n <= SERIES_TERMS; n++) begin
            term = div_small((term * a) >> 32, n);
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        e = (sum + 64'd32768) >> 16;
        return (e > 64'd65535) ? {EXP_VAL_W{1'b1}} : e[EXP_VAL_W-1:0];
    endfunction

    function automatic t_exp_tab build_exp_tab();
        t_exp_tab t;
        for (int unsigned k = 0; k < EXP_TABLE_ENTRIES; k++) begin
            t[k] = exp_entry(k);
        end
        return t;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

// ===== design/sbw_weight.sv =====
// Radial weight w = r2 * 2^-(r2*inv_spread*log2e), Q18.14, saturated to 32 bits.
// Five register stages; each stage loads when its enable is high.
module sbw_weight (
    input  logic                              i_clk,
    input  logic [sbw_pkg::WGT_STG-1:0]       i_en,
    input  logic [sbw_pkg::R2_W-1:0]          i_r2,
    input  logic [sbw_pkg::SPREAD_W-1:0]      i_inv_spread,
    output logic [sbw_pkg::WGT_W-1:0]         o_w
);

    logic [sbw_pkg::X_W-1:0]       n_x;
    logic                          r_big_a;
    logic [sbw_pkg::XLIM_W-1:0]    r_x_a;
    logic [sbw_pkg::R2_W-1:0]      r_r2_a;

    logic [sbw_pkg::YP_W-1:0]      n_yp;
    logic [sbw_pkg::Y_W-1:0]       n_y;
    logic [sbw_pkg::EXPN_W-1:0]    n_n;
    logic                          r_zero_b;
    logic [sbw_pkg::EXPN_W-1:0]    r_n_b;
    logic [sbw_pkg::EXP_IDX_W-1:0] r_idx_b;
    logic [sbw_pkg::R2_W-1:0]      r_r2_b;

    logic                          r_zero_c;
    logic [sbw_pkg::EXPN_W-1:0]    r_n_c;
    logic [sbw_pkg::EXP_VAL_W-1:0] r_ent_c;
    logic [sbw_pkg::R2_W-1:0]      r_r2_c;

    logic                          r_zero_d;
    logic [sbw_pkg::EXPN_W-1:0]    r_n_d;
    logic [sbw_pkg::WPROD_W-1:0]   r_prod_d;

    logic [sbw_pkg::WPROD_W-1:0]   n_shifted;
    logic [sbw_pkg::WGT_W-1:0]     r_w;

    assign n_x  = sbw_pkg::X_W'(i_r2) * sbw_pkg::X_W'(i_inv_spread);
    assign n_yp = sbw_pkg::YP_W'(r_x_a) * sbw_pkg::YP_W'(sbw_pkg::LOG2E_Q30);
    assign n_y  = n_yp[sbw_pkg::YP_W-1:sbw_pkg::LOG2E_SH];
    assign n_n  = n_y[sbw_pkg::Y_W-1:sbw_pkg::FRAC_W];
    assign n_shifted = (r_prod_d >> r_n_d) >> sbw_pkg::WGT_PRE_SH;

    always_ff @(posedge i_clk) begin
        // x = r2 * inv_spread; anything at or above 64.0 gives a zero weight.
        if (i_en[0]) begin
            r_big_a <= |n_x[sbw_pkg::X_W-1:sbw_pkg::XLIM_W];
            r_x_a   <= n_x[sbw_pkg::XLIM_W-1:0];
            r_r2_a  <= i_r2;
        end
        // Base-2 exponent: integer part shifts, top fraction bits index the table.
        if (i_en[1]) begin
            r_zero_b <= r_big_a || (n_n >= sbw_pkg::EXPN_LIMIT);
            r_n_b    <= n_n;
            r_idx_b  <= n_y[sbw_pkg::FRAC_W-1 -: sbw_pkg::EXP_IDX_W];
            r_r2_b   <= r_r2_a;
        end
        if (i_en[2]) begin
            r_zero_c <= r_zero_b;
            r_n_c    <= r_n_b;
            r_ent_c  <= sbw_pkg::EXP_TAB[r_idx_b];
            r_r2_c   <= r_r2_b;
        end
        if (i_en[3]) begin
            r_zero_d <= r_zero_c;
            r_n_d    <= r_n_c;
            r_prod_d <= sbw_pkg::WPROD_W'(r_r2_c) * sbw_pkg::WPROD_W'(r_ent_c);
        end
        if (i_en[4]) begin
            if (r_zero_d) begin
                r_w <= '0;
            end else if (|n_shifted[sbw_pkg::WPROD_W-1:sbw_pkg::WGT_W]) begin
                r_w <= '1;
            end else begin
                r_w <= n_shifted[sbw_pkg::WGT_W-1:0];
            end
        end
    end

    assign o_w = r_w;

endmodule

// ===== design/spectral_bin_weighting.sv =====
// Channel   Direction  Signals                          Content
// ------------------------------------------------------------------------------
// in        request    i_in_valid / o_in_ready          i_in_req: bin index, target, pattern
// out       response   o_out_valid / i_out_ready        o_out_rsp: weighted bin, clip flag
// cfg       write      i_cfg_we, i_cfg_idx, i_cfg_data  geometry, spread, mode
//
// One request is taken per clock while the output is not stalled; each response is
// presented from the last of the ten pipeline stages, and the 32x33 scaling multiply is
// the widest stage. A stalled output holds only the stages that are full: bubbles behind
// it keep closing, so requests are still taken until every stage holds one.
// Reset (i_rst_n low at a clock edge) empties the pipeline and loads the register defaults.
module spectral_bin_weighting (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  sbw_pkg::t_in_req                i_in_req,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output sbw_pkg::t_out_rsp               o_out_rsp,

    input  logic                            i_cfg_we,
    input  logic [sbw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sbw_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers.
    logic [sbw_pkg::SIZE_W-1:0]   r_frame_height;
    logic [sbw_pkg::SIZE_W-1:0]   r_frame_width;
    logic [sbw_pkg::SPREAD_W-1:0] r_inv_spread;
    logic                         r_correlate_mode;

    // Pipeline control: one valid bit per stage, and a load enable per stage that is
    // high when the stage is empty or the stage after it moves.
    logic [sbw_pkg::NSTG-1:0] r_vld;
    logic [sbw_pkg::NSTG-1:0] en;

    // Stage 0: wrapped indices and the four cross products.
    logic signed [sbw_pkg::SAMP_W-1:0]   tr, ti, pr, pi;
    logic        [sbw_pkg::DIM_W-1:0]    half_h, half_w;
    logic signed [sbw_pkg::DIFF_W-1:0]   n_di, n_dj;
    logic signed [sbw_pkg::DIFF_W-1:0]   r_di, r_dj;
    logic signed [2*sbw_pkg::SAMP_W-1:0] r_pp_rr, r_pp_ii, r_pp_ir, r_pp_ri;
    logic signed [sbw_pkg::SAMP_W-1:0]   r_tr, r_ti;

    // Stage 1: squared indices and the complex value to be weighted.
    logic signed [2*sbw_pkg::DIFF_W-1:0] n_sqi, n_sqj;
    logic        [sbw_pkg::SQ_W-1:0]     r_sqi, r_sqj;
    logic signed [sbw_pkg::CORR_W-1:0]   n_vr, n_vi;

    // Stage 2: radius squared.
    logic [sbw_pkg::R2_W-1:0] r_r2;

    // The complex value rides alongside the weight unit, stages 1 through 7.
    logic signed [sbw_pkg::CORR_W-1:0] r_vr [1:sbw_pkg::MUL_STG-1];
    logic signed [sbw_pkg::CORR_W-1:0] r_vi [1:sbw_pkg::MUL_STG-1];

    // Stages 3..7 live in the weight unit; stage 8 scales, stage 9 saturates.
    logic [sbw_pkg::WGT_W-1:0]         w;
    logic signed [sbw_pkg::PROD_W-1:0] n_pre, n_pim;
    logic signed [sbw_pkg::PROD_W-1:0] r_pre, r_pim;
    logic [sbw_pkg::OUT_W:0]           sat_re, sat_im;
    sbw_pkg::t_out_rsp                 r_out;

    // Floor shift by 14 is already done by the part-select; this clips to 48 bits.
    // Returns the clip flag above the clipped value.
    function automatic logic [sbw_pkg::OUT_W:0] sat_part(
        input logic signed [sbw_pkg::SH_W-1:0] v
    );
        logic [sbw_pkg::OUT_W:0] res;
        if (!v[sbw_pkg::SH_W-1] && (|v[sbw_pkg::SH_W-2:sbw_pkg::OUT_W-1])) begin
            res = {1'b1, sbw_pkg::OUT_MAX};
        end else if (v[sbw_pkg::SH_W-1] && !(&v[sbw_pkg::SH_W-2:sbw_pkg::OUT_W-1])) begin
            res = {1'b1, sbw_pkg::OUT_MIN};
        end else begin
            res = {1'b0, v[sbw_pkg::OUT_W-1:0]};
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------------------
    // Configuration writes. The user must make them only while the pipeline is idle (the
    // block itself does not enforce this), since every stage reads the registers directly.
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_height   <= sbw_pkg::SIZE_W'(256);
            r_frame_width    <= sbw_pkg::SIZE_W'(256);
            r_inv_spread     <= sbw_pkg::SPREAD_W'(65536);
            r_correlate_mode <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (sbw_pkg::t_cfg_reg'(i_cfg_idx))
                sbw_pkg::CFG_FRAME_HEIGHT: r_frame_height   <= i_cfg_data[sbw_pkg::SIZE_W-1:0];
                sbw_pkg::CFG_FRAME_WIDTH:  r_frame_width    <= i_cfg_data[sbw_pkg::SIZE_W-1:0];
                sbw_pkg::CFG_INV_SPREAD:   r_inv_spread     <= i_cfg_data[sbw_pkg::SPREAD_W-1:0];
                sbw_pkg::CFG_CORR_MODE:    r_correlate_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage enables. The chain runs from the output back to the input, so a bubble
    // anywhere lets everything upstream of it advance.
    // ---------------------------------------------------------------------------------
    always_comb begin
        en[sbw_pkg::NSTG-1] = !r_vld[sbw_pkg::NSTG-1] || i_out_ready;
        for (int k = sbw_pkg::NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < sbw_pkg::NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[sbw_pkg::NSTG-1];
    assign o_out_rsp   = r_out;

    // ---------------------------------------------------------------------------------
    // Stage 0. An index at or above half the frame size has the size subtracted, which
    // maps it to a signed frequency. The four 16x16 products run side by side.
    // ---------------------------------------------------------------------------------
    assign tr = i_in_req.target_re;
    assign ti = i_in_req.target_im;
    assign pr = i_in_req.pattern_re;
    assign pi = i_in_req.pattern_im;

    assign half_h = r_frame_height[sbw_pkg::SIZE_W-1:1];
    assign half_w = r_frame_width[sbw_pkg::SIZE_W-1:1];

    always_comb begin
        if (i_in_req.row >= half_h) begin
            n_di = $signed({2'b00, i_in_req.row}) - $signed({1'b0, r_frame_height});
        end else begin
            n_di = $signed({2'b00, i_in_req.row});
        end
        if (i_in_req.col >= half_w) begin
            n_dj = $signed({2'b00, i_in_req.col}) - $signed({1'b0, r_frame_width});
        end else begin
            n_dj = $signed({2'b00, i_in_req.col});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_di    <= n_di;
            r_dj    <= n_dj;
            r_pp_rr <= (2*sbw_pkg::SAMP_W)'(tr) * (2*sbw_pkg::SAMP_W)'(pr);
            r_pp_ii <= (2*sbw_pkg::SAMP_W)'(ti) * (2*sbw_pkg::SAMP_W)'(pi);
            r_pp_ir <= (2*sbw_pkg::SAMP_W)'(ti) * (2*sbw_pkg::SAMP_W)'(pr);
            r_pp_ri <= (2*sbw_pkg::SAMP_W)'(tr) * (2*sbw_pkg::SAMP_W)'(pi);
            r_tr    <= tr;
            r_ti    <= ti;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 1. Squares of the wrapped indices are never negative and fit in 20 bits.
    // Correlate mode forms target * conj(pattern); plain mode passes the target through.
    // ---------------------------------------------------------------------------------
    assign n_sqi = r_di * r_di;
    assign n_sqj = r_dj * r_dj;

    always_comb begin
        if (r_correlate_mode) begin
            n_vr = sbw_pkg::CORR_W'(r_pp_rr) + sbw_pkg::CORR_W'(r_pp_ii);
            n_vi = sbw_pkg::CORR_W'(r_pp_ir) - sbw_pkg::CORR_W'(r_pp_ri);
        end else begin
            n_vr = sbw_pkg::CORR_W'(r_tr);
            n_vi = sbw_pkg::CORR_W'(r_ti);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_sqi   <= n_sqi[sbw_pkg::SQ_W-1:0];
            r_sqj   <= n_sqj[sbw_pkg::SQ_W-1:0];
            r_vr[1] <= n_vr;
            r_vi[1] <= n_vi;
        end
        for (int k = 2; k < sbw_pkg::MUL_STG; k++) begin
            if (en[k]) begin
                r_vr[k] <= r_vr[k-1];
                r_vi[k] <= r_vi[k-1];
            end
        end
        if (en[2]) begin
            r_r2 <= sbw_pkg::R2_W'(r_sqi) + sbw_pkg::R2_W'(r_sqj);
        end
    end

    // ---------------------------------------------------------------------------------
    // Stages 3 to 7: the radial weight.
    // ---------------------------------------------------------------------------------
    sbw_weight u_weight (
        .i_clk        (i_clk),
        .i_en         (en[sbw_pkg::MUL_STG-1:sbw_pkg::WGT_FIRST]),
        .i_r2         (r_r2),
        .i_inv_spread (r_inv_spread),
        .o_w          (w)
    );

    // ---------------------------------------------------------------------------------
    // Stage 8: signed value times unsigned weight, exact. Stage 9: arithmetic shift
    // right by 14 (rounds toward minus infinity) and clip to 48 bits.
    // ---------------------------------------------------------------------------------
    assign n_pre = sbw_pkg::PROD_W'(r_vr[sbw_pkg::MUL_STG-1])
                 * sbw_pkg::PROD_W'($signed({1'b0, w}));
    assign n_pim = sbw_pkg::PROD_W'(r_vi[sbw_pkg::MUL_STG-1])
                 * sbw_pkg::PROD_W'($signed({1'b0, w}));

    assign sat_re = sat_part(r_pre[sbw_pkg::PROD_W-1:sbw_pkg::SCALE_SH]);
    assign sat_im = sat_part(r_pim[sbw_pkg::PROD_W-1:sbw_pkg::SCALE_SH]);

    always_ff @(posedge i_clk) begin
        if (en[sbw_pkg::MUL_STG]) begin
            r_pre <= n_pre;
            r_pim <= n_pim;
        end
        if (en[sbw_pkg::NSTG-1]) begin
            r_out.out_re    <= sat_re[sbw_pkg::OUT_W-1:0];
            r_out.out_im    <= sat_im[sbw_pkg::OUT_W-1:0];
            r_out.saturated <= sat_re[sbw_pkg::OUT_W] | sat_im[sbw_pkg::OUT_W];
        end
    end

    // ---------------------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------------------

    // Requests are refused only when every stage is full and the output is stalled.
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && (&r_vld)))
        else $error("input refused while the pipeline had room");

    // A clipped response carries a limit value in at least one part.
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.saturated) |->
            (o_out_rsp.out_re == sbw_pkg::OUT_MAX || o_out_rsp.out_re == sbw_pkg::OUT_MIN ||
             o_out_rsp.out_im == sbw_pkg::OUT_MAX || o_out_rsp.out_im == sbw_pkg::OUT_MIN))
        else $error("saturated flag set without a clipped part");

    // The scaling stage, when it holds a request and cannot move, keeps it.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[sbw_pkg::MUL_STG] && !en[sbw_pkg::MUL_STG]) |=> r_vld[sbw_pkg::MUL_STG])
        else $error("scaling stage dropped a stalled request");

    // Nothing leaves the pipeline right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule
